[hdl/freivalds_product_check_macros.svh]
// Assertion macros for the Freivalds product checker.
// Expects clk and rst_n in the scope of each use.
`ifndef FREIVALDS_PRODUCT_CHECK_MACROS_SVH
`define FREIVALDS_PRODUCT_CHECK_MACROS_SVH

`define FPC_CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FPC_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fpc_pkg.sv]
// Shared types and constants for the Freivalds product checker.
// No dependencies; used by fpc_mac_unit and freivalds_product_check.
package fpc_pkg;

  localparam int SUM_W      = 32;
  localparam int SIZE_W     = 5;
  localparam int IN_IDX_W   = 4;
  localparam int IN_VALUE_W = 16;
  localparam int TV_W       = 16;
  localparam int TV_IDX_W   = 4;

  typedef enum logic [1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_LOAD_C = 2'd2,
    MODE_CHECK  = 2'd3
  } mode_t;

  typedef struct packed {
    logic valid;
    logic phase_ac;
    logic first;
    logic last;
  } mac_tag_t;

  typedef struct packed {
    logic done;
    logic phase_ac;
    logic mismatch;
  } mac_status_t;

endpackage

[hdl/fpc_mac_unit.sv]
// Shared multiply-accumulate unit: product stage, then row accumulators.
// Depends on fpc_pkg for the tag and status structs.
module fpc_mac_unit import fpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mac_tag_t          tag_i,
  input  logic              xbit_i,
  input  logic [SUM_W-1:0]  elem_i,
  input  logic [SUM_W-1:0]  bx_i,
  input  logic [SUM_W-1:0]  celem_i,
  output logic              busy_o,
  output mac_status_t       status_o,
  output logic [SUM_W-1:0]  row_sum_o
);

  mac_tag_t         tag2_r, tag3_r;
  logic [SUM_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0] cterm_r, cterm_nxt;
  logic [SUM_W-1:0] acc_p_r, acc_p_nxt;
  logic [SUM_W-1:0] acc_c_r, acc_c_nxt;

  always_comb begin
    if (tag_i.phase_ac) begin
      prod_nxt = elem_i * bx_i;
    end else begin
      prod_nxt = xbit_i ? elem_i : '0;
    end
    cterm_nxt = xbit_i ? celem_i : '0;
  end

  always_comb begin
    acc_p_nxt = (tag2_r.first ? '0 : acc_p_r) + prod_r;
    acc_c_nxt = (tag2_r.first ? '0 : acc_c_r) + cterm_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag2_r <= tag_i;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    cterm_r <= cterm_nxt;
    if (tag2_r.valid) begin
      acc_p_r <= acc_p_nxt;
      acc_c_r <= acc_c_nxt;
    end
  end

  assign busy_o            = tag2_r.valid | tag3_r.valid;
  assign status_o.done     = tag3_r.valid & tag3_r.last;
  assign status_o.phase_ac = tag3_r.phase_ac;
  assign status_o.mismatch = (acc_p_r != acc_c_r);
  assign row_sum_o         = acc_p_r;

endmodule

[hdl/freivalds_product_check.sv]
// Freivalds product checker top level: element stores, sequencer, result register.
// Depends on fpc_pkg, fpc_mac_unit and freivalds_product_check_macros.svh.
//
//   channel  | handshake                 | word
//   ---------+---------------------------+------------------------------------------
//   in       | in_valid / in_ready       | in_mode, in_row, in_col, in_value,
//            |                           | in_test_vector
//   out      | out_valid / out_ready     | out_products_match
//   cfg      | cfg_wr_en                 | cfg_wr_data (matrix size)
//
// A load word leaves in_ready high. A check word holds in_ready low for one pass of
// n*n steps for B*X, one of n*n steps for A*(B*X) and C*X through the one shared
// multiplier, each followed by a pipeline drain, then the finish state.
// A check at size 0 goes straight to the finish state.
// A finished flag waits in the output register and the next word is accepted meanwhile;
// a later flag holds in finish until that register frees. Reset is synchronous; stores
// need no clear.
module freivalds_product_check import fpc_pkg::*; #(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_mode,
  input  logic [IN_IDX_W-1:0]          in_row,
  input  logic [IN_IDX_W-1:0]          in_col,
  input  logic signed [IN_VALUE_W-1:0] in_value,
  input  logic [TV_W-1:0]              in_test_vector,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_products_match,
  input  logic                         cfg_wr_en,
  input  logic [SIZE_W-1:0]            cfg_wr_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_BX       = 6'b000010,
    ST_BX_DRAIN = 6'b000100,
    ST_AC       = 6'b001000,
    ST_AC_DRAIN = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt, wr_i_r, wr_i_nxt;
  logic [IDX_W-1:0]  nm1_r;
  logic [TV_W-1:0]   tv_r;
  logic              ok_r, ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_match_r;

  logic [ELEM_WIDTH-1:0] store_a [DEPTH];
  logic [ELEM_WIDTH-1:0] store_b [DEPTH];
  logic [ELEM_WIDTH-1:0] store_c [DEPTH];
  logic [SUM_W-1:0]      bx_mem  [MAX_DIM];
  logic [ELEM_WIDTH-1:0] a_q, b_q, c_q;
  logic [SUM_W-1:0]      bx_q;

  mac_tag_t         tag1_r, tag1_nxt;
  logic             xbit1_r;
  mac_status_t      mac_status;
  logic             mac_busy;
  logic [SUM_W-1:0] row_sum;
  logic [SUM_W-1:0] elem_ab, elem_c;

  logic             in_fire, is_check, load_ok;
  logic [SUM_W-1:0] value_ext, waddr_full, raddr_full, j_full, n_full, nm1_full;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ELEM_WIDTH-1:0] wdata;
  logic             issue, j_last, i_last, xbit, drained;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign is_check = (mode_t'(in_mode) == MODE_CHECK);

  assign value_ext  = SUM_W'(in_value);
  assign wdata      = value_ext[ELEM_WIDTH-1:0];
  assign waddr_full = SUM_W'(in_row) * SUM_W'(MAX_DIM) + SUM_W'(in_col);
  assign waddr      = waddr_full[ADDR_W-1:0];
  assign load_ok    = in_fire && !is_check && (SUM_W'(in_row) < SUM_W'(MAX_DIM))
                      && (SUM_W'(in_col) < SUM_W'(MAX_DIM));

  assign n_full   = (SUM_W'(size_r) > SUM_W'(MAX_DIM)) ? SUM_W'(MAX_DIM) : SUM_W'(size_r);
  assign nm1_full = n_full - SUM_W'(1);

  assign issue      = (state_r == ST_BX) || (state_r == ST_AC);
  assign j_last     = (j_r == nm1_r);
  assign i_last     = (i_r == nm1_r);
  assign raddr_full = SUM_W'(i_r) * SUM_W'(MAX_DIM) + SUM_W'(j_r);
  assign raddr      = raddr_full[ADDR_W-1:0];
  assign j_full     = SUM_W'(j_r);
  assign xbit       = (j_full < SUM_W'(TV_W)) ? tv_r[j_full[TV_IDX_W-1:0]] : 1'b0;
  assign drained    = !tag1_r.valid && !mac_busy;

  always_comb begin
    tag1_nxt.valid    = issue;
    tag1_nxt.phase_ac = (state_r == ST_AC);
    tag1_nxt.first    = (j_r == '0);
    tag1_nxt.last     = j_last;
  end

  // storage: one write port for loads (bx_mem from MAC row sums), one registered read port for the sequencer
  always_ff @(posedge clk) begin
    if (load_ok && (mode_t'(in_mode) == MODE_LOAD_A)) begin
      store_a[waddr] <= wdata;
    end
    if (load_ok && (mode_t'(in_mode) == MODE_LOAD_B)) begin
      store_b[waddr] <= wdata;
    end
    if (load_ok && (mode_t'(in_mode) == MODE_LOAD_C)) begin
      store_c[waddr] <= wdata;
    end
    if (mac_status.done && !mac_status.phase_ac) begin
      bx_mem[wr_i_r] <= row_sum;
    end
    a_q  <= store_a[raddr];
    b_q  <= store_b[raddr];
    c_q  <= store_c[raddr];
    bx_q <= bx_mem[j_r];
  end

  assign elem_ab = tag1_r.phase_ac ? SUM_W'(signed'(a_q)) : SUM_W'(signed'(b_q));
  assign elem_c  = SUM_W'(signed'(c_q));

  fpc_mac_unit u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (tag1_r),
    .xbit_i    (xbit1_r),
    .elem_i    (elem_ab),
    .bx_i      (bx_q),
    .celem_i   (elem_c),
    .busy_o    (mac_busy),
    .status_o  (mac_status),
    .row_sum_o (row_sum)
  );

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    wr_i_nxt      = wr_i_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (mac_status.done && !mac_status.phase_ac) begin
      wr_i_nxt = wr_i_r + IDX_W'(1);
    end
    if (mac_status.done && mac_status.phase_ac && mac_status.mismatch) begin
      ok_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && is_check) begin
          i_nxt    = '0;
          j_nxt    = '0;
          wr_i_nxt = '0;
          if (size_r == '0) begin
            ok_nxt    = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            ok_nxt    = 1'b1;
            state_nxt = ST_BX;
          end
        end
      end
      ST_BX, ST_AC: begin
        if (j_last) begin
          j_nxt = '0;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = (state_r == ST_BX) ? ST_BX_DRAIN : ST_AC_DRAIN;
          end else begin
            i_nxt = i_r + IDX_W'(1);
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_BX_DRAIN: begin
        if (drained) begin
          state_nxt = ST_AC;
        end
      end
      ST_AC_DRAIN: begin
        if (drained) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SIZE_W'(16);
      i_r         <= '0;
      j_r         <= '0;
      wr_i_r      <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
      tag1_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      wr_i_r      <= wr_i_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
      tag1_r      <= tag1_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    xbit1_r <= xbit;
    if (in_fire && is_check) begin
      tv_r  <= in_test_vector;
      nm1_r <= nm1_full[IDX_W-1:0];
    end
    if ((state_r == ST_FINISH) && (!out_valid_r || out_ready)) begin
      out_match_r <= ok_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_products_match = out_match_r;

`include "freivalds_product_check_macros.svh"

  `FPC_CHK_SAME(a_out_from_finish, $rose(out_valid_r), $past(state_r) == ST_FINISH, "result raised outside finish")
  `FPC_CHK_SAME(a_no_bx_write_in_ac, state_r == ST_AC, !(mac_status.done && !mac_status.phase_ac), "B*X row written during A/C pass")
  `FPC_CHK_NEXT(a_check_starts, in_fire && is_check, state_r == ST_BX || state_r == ST_FINISH, "check word did not start a pass")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for freivalds_product_check: loads A, B and C element words, runs checks
// at several matrix sizes and compares each products_match word with a local predictor.
// Depends on fpc_pkg and the freivalds_product_check RTL.
module tb;
  import fpc_pkg::*;

  localparam int DIM            = 16;
  localparam int ITEM_TARGET    = 1400;
  localparam int MIN_RAND_CHECK = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int END_CYCLES     = 600;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_mode = MODE_LOAD_A;
  logic [IN_IDX_W-1:0]   in_row = '0;
  logic [IN_IDX_W-1:0]   in_col = '0;
  logic [IN_VALUE_W-1:0] in_value = '0;
  logic [TV_W-1:0]       in_test_vector = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_products_match;
  logic                  cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0]     cfg_wr_data = '0;

  logic signed [IN_VALUE_W-1:0] mat_a [DIM][DIM];
  logic signed [IN_VALUE_W-1:0] mat_b [DIM][DIM];
  logic signed [IN_VALUE_W-1:0] mat_c [DIM][DIM];
  logic [SIZE_W-1:0]            size_reg = SIZE_W'(DIM);
  logic                         pending_matches [$];

  int words_sent = 0;
  int err_count = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  freivalds_product_check #(
    .MAX_DIM(DIM),
    .ELEM_WIDTH(16)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_row(in_row),
    .in_col(in_col),
    .in_value(in_value),
    .in_test_vector(in_test_vector),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_products_match(out_products_match),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] widen(logic [IN_VALUE_W-1:0] e);
    return {{(32 - IN_VALUE_W){e[IN_VALUE_W-1]}}, e};
  endfunction

  function automatic logic predict_products_match(logic [TV_W-1:0] tv);
    int unsigned dim;
    logic [31:0] bx [DIM];
    logic [31:0] abx;
    logic [31:0] cx;
    logic ok;
    dim = (size_reg > DIM) ? DIM : size_reg;
    if (dim == 0) return 1'b0;
    for (int i = 0; i < dim; i++) begin
      bx[i] = '0;
      for (int j = 0; j < dim; j++) begin
        if (tv[j]) bx[i] += widen(mat_b[i][j]);
      end
    end
    ok = 1'b1;
    for (int i = 0; i < dim; i++) begin
      abx = '0;
      cx = '0;
      for (int j = 0; j < dim; j++) begin
        abx += widen(mat_a[i][j]) * bx[j];
        if (tv[j]) cx += widen(mat_c[i][j]);
      end
      if (abx != cx) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic send_word(mode_t mode, logic [3:0] r, logic [3:0] c,
                           logic [15:0] v, logic [15:0] tv);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode = mode;
    in_row = r;
    in_col = c;
    in_value = v;
    in_test_vector = tv;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    case (mode)
      MODE_LOAD_A: mat_a[r][c] = v;
      MODE_LOAD_B: mat_b[r][c] = v;
      MODE_LOAD_C: mat_c[r][c] = v;
      default: pending_matches.push_back(predict_products_match(tv));
    endcase
  endtask

  task automatic load_element(mode_t mode, int r, int c, logic [15:0] v);
    send_word(mode, 4'(r), 4'(c), v, 16'($urandom));
  endtask

  task automatic run_check(logic [15:0] tv);
    send_word(MODE_CHECK, 4'($urandom), 4'($urandom), 16'($urandom), tv);
  endtask

  // A and B get small values so that C = A*B fits the element width.
  task automatic load_consistent(int dim);
    int sum;
    for (int i = 0; i < dim; i++) begin
      for (int j = 0; j < dim; j++) load_element(MODE_LOAD_A, i, j, 16'(int'($urandom_range(0, 15)) - 8));
    end
    for (int i = 0; i < dim; i++) begin
      for (int j = 0; j < dim; j++) load_element(MODE_LOAD_B, i, j, 16'(int'($urandom_range(0, 15)) - 8));
    end
    for (int i = 0; i < dim; i++) begin
      for (int j = 0; j < dim; j++) begin
        sum = 0;
        for (int k = 0; k < dim; k++) sum += int'(mat_a[i][k]) * int'(mat_b[k][j]);
        load_element(MODE_LOAD_C, i, j, 16'(sum));
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
  endtask

  task automatic set_matrix_size(logic [SIZE_W-1:0] n);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_data = n;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    size_reg = n;
  endtask

  task automatic test_size_zero();
    set_matrix_size(0);
    run_check(16'hFFFF);
    run_check(16'h0000);
  endtask

  task automatic test_size_one();
    set_matrix_size(1);
    load_element(MODE_LOAD_A, 0, 0, 16'h8000);
    load_element(MODE_LOAD_B, 0, 0, 16'h8000);
    load_element(MODE_LOAD_C, 0, 0, 16'h8000);
    run_check(16'h0001);
    run_check(16'hFFFE);
    load_element(MODE_LOAD_A, 0, 0, 16'h7FFF);
    load_element(MODE_LOAD_B, 0, 0, 16'h0001);
    load_element(MODE_LOAD_C, 0, 0, 16'h7FFF);
    run_check(16'hFFFF);
    load_element(MODE_LOAD_A, 15, 15, 16'h8000);
    load_element(MODE_LOAD_B, 15, 15, 16'h7FFF);
    load_element(MODE_LOAD_C, 15, 15, 16'h8000);
    run_check(16'h8001);
  endtask

  task automatic test_full_size();
    load_consistent(DIM);
    set_matrix_size(16);
    run_check(16'hFFFF);
    run_check(16'h0000);
    repeat (3) run_check(16'($urandom));
    set_matrix_size(31);
    run_check(16'hFFFF);
    run_check(16'($urandom));
    load_element(MODE_LOAD_C, $urandom_range(0, 15), $urandom_range(0, 15), 16'($urandom));
    repeat (3) run_check(16'($urandom));
    set_matrix_size(17);
    run_check(16'hFFFF);
  endtask

  task automatic test_backpressure();
    set_matrix_size(2);
    load_consistent(2);
    hold_req = 1'b1;
    repeat (6) run_check(16'($urandom));
  endtask

  task automatic test_random_sequences();
    int n;
    int dim;
    int pick;
    int checks_done;
    checks_done = 0;
    while (words_sent < ITEM_TARGET || checks_done < MIN_RAND_CHECK) begin
      no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) n = $urandom_range(1, 4);
      else if (pick < 9) n = $urandom_range(5, 16);
      else n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
      set_matrix_size(SIZE_W'(n));
      dim = (n > DIM) ? DIM : n;
      if (dim != 0 && dim <= 6 && $urandom_range(0, 4) != 0) load_consistent(dim);
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 2) == 0) begin
          load_element(mode_t'($urandom_range(0, 2)), $urandom_range(0, 15),
                       $urandom_range(0, 15), 16'($urandom));
        end else begin
          run_check(16'($urandom));
          checks_done++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic check_result(logic got);
    logic want;
    if (pending_matches.size() == 0) begin
      $error("products_match: no word expected, actual %0b", got);
      err_count++;
    end else begin
      want = pending_matches.pop_front();
      if (got !== want) begin
        $error("products_match: expected %0b, actual %0b", want, got);
        err_count++;
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      @(negedge clk);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result(out_products_match);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_size_zero();
    test_size_one();
    test_full_size();
    test_backpressure();
    test_random_sequences();
    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
